[rtl/core/drill_motor_soft_start_trip_defines.svh]
// Assertion macros used by the drill motor controller core.
`ifndef DRILL_MOTOR_SOFT_START_TRIP_DEFINES_SVH
`define DRILL_MOTOR_SOFT_START_TRIP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define DMST_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define DMST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/dmst_pkg.sv]
// Types, constants and helper functions of the drill motor controller.
`default_nettype none
package dmst_pkg;

    // Field and register widths.
    localparam int unsigned ADC_W      = 10;
    localparam int unsigned DUTY_W     = 8;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;
    localparam logic [DUTY_W-1:0]  DUTY_MAX         = '1;
    localparam logic [DUTY_W-1:0]  RAMP_RESET_VALUE = 8'd50;

    // Register reset values.
    localparam logic [COUNT_W-1:0] DEF_DEBOUNCE      = 16'd200;
    localparam logic [COUNT_W-1:0] DEF_RAMP_INTERVAL = 16'd100;
    localparam logic [DUTY_W-1:0]  DEF_RAMP_STEP     = 8'd10;
    localparam logic [DUTY_W-1:0]  DEF_RAMP_START    = 8'd50;
    localparam logic [ADC_W-1:0]   DEF_OC_LEVEL      = 10'd14;
    localparam logic [COUNT_W-1:0] DEF_RECHECK       = 16'd400;
    localparam logic [COUNT_W-1:0] DEF_TRIP_HOLD     = 16'd2000;

    // Register indexes (byte address divided by four).
    typedef enum logic [2:0] {
        REG_DEBOUNCE      = 3'd0,
        REG_RAMP_INTERVAL = 3'd1,
        REG_RAMP_STEP     = 3'd2,
        REG_RAMP_START    = 3'd3,
        REG_OC_LEVEL      = 3'd4,
        REG_RECHECK       = 3'd5,
        REG_TRIP_HOLD     = 3'd6
    } t_reg_idx;

    // Controller phase; codes above PH_HOLD behave as PH_RUN.
    typedef enum logic [2:0] {
        PH_RUN      = 3'd0,
        PH_WAIT_PWR = 3'd1,
        PH_WAIT_DIR = 3'd2,
        PH_RECHECK  = 3'd3,
        PH_HOLD     = 3'd4
    } t_phase;

    // Configuration register set.
    typedef struct packed {
        logic [COUNT_W-1:0] debounce_ticks;
        logic [COUNT_W-1:0] ramp_interval_ticks;
        logic [DUTY_W-1:0]  ramp_step;
        logic [DUTY_W-1:0]  ramp_start;
        logic [ADC_W-1:0]   overcurrent_level;
        logic [COUNT_W-1:0] recheck_ticks;
        logic [COUNT_W-1:0] trip_hold_ticks;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic              drive_enable;
        logic [DUTY_W-1:0] duty_forward;
        logic [DUTY_W-1:0] duty_reverse;
        logic              lamp_power;
        logic              lamp_forward;
        logic              lamp_reverse;
        logic              lamp_fault;
    } t_result;

    // Scales a pot reading to a duty: floor(pot * 255 / 1023).
    // The quotient estimate x >> 10 is low by at most one, so one compare corrects it.
    function automatic logic [DUTY_W-1:0] pot_to_target(input logic [ADC_W-1:0] pot);
        logic [17:0]       prod;
        logic [DUTY_W-1:0] q0;
        logic [10:0]       rem;
        prod = {pot, 8'b0} - {8'b0, pot};
        q0   = prod[17:10];
        rem  = {1'b0, prod[9:0]} + {3'b0, q0};
        return (rem >= 11'd1023) ? q0 + 8'd1 : q0;
    endfunction

endpackage
`default_nettype wire

[rtl/core/dmst_if.sv]
// Tick input and result output channel interfaces of the drill motor controller.
`default_nettype none
interface dmst_tick_if;
    logic       valid;
    logic       ready;
    logic       power_button;
    logic       direction_button;
    logic [9:0] pot_sample;
    logic [9:0] shunt_sample;

    modport source (output valid, output power_button, output direction_button,
                    output pot_sample, output shunt_sample, input ready);
    modport sink   (input valid, input power_button, input direction_button,
                    input pot_sample, input shunt_sample, output ready);
endinterface

interface dmst_result_if;
    logic       valid;
    logic       ready;
    logic       drive_enable;
    logic [7:0] duty_forward;
    logic [7:0] duty_reverse;
    logic       lamp_power;
    logic       lamp_forward;
    logic       lamp_reverse;
    logic       lamp_fault;

    modport source (output valid, output drive_enable, output duty_forward,
                    output duty_reverse, output lamp_power, output lamp_forward,
                    output lamp_reverse, output lamp_fault, input ready);
    modport sink   (input valid, input drive_enable, input duty_forward,
                    input duty_reverse, input lamp_power, input lamp_forward,
                    input lamp_reverse, input lamp_fault, output ready);
endinterface
`default_nettype wire

[rtl/core/dmst_regs.sv]
// APB configuration register file of the drill motor controller.
`default_nettype none
module dmst_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [dmst_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [dmst_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [dmst_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output dmst_pkg::t_cfg                        o_cfg
);
    import dmst_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    // Register writes complete in the access phase of a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks      <= DEF_DEBOUNCE;
            r_cfg.ramp_interval_ticks <= DEF_RAMP_INTERVAL;
            r_cfg.ramp_step           <= DEF_RAMP_STEP;
            r_cfg.ramp_start          <= DEF_RAMP_START;
            r_cfg.overcurrent_level   <= DEF_OC_LEVEL;
            r_cfg.recheck_ticks       <= DEF_RECHECK;
            r_cfg.trip_hold_ticks     <= DEF_TRIP_HOLD;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DEBOUNCE:      r_cfg.debounce_ticks      <= pwdata[COUNT_W-1:0];
                REG_RAMP_INTERVAL: r_cfg.ramp_interval_ticks <= pwdata[COUNT_W-1:0];
                REG_RAMP_STEP:     r_cfg.ramp_step           <= pwdata[DUTY_W-1:0];
                REG_RAMP_START:    r_cfg.ramp_start          <= pwdata[DUTY_W-1:0];
                REG_OC_LEVEL:      r_cfg.overcurrent_level   <= pwdata[ADC_W-1:0];
                REG_RECHECK:       r_cfg.recheck_ticks       <= pwdata[COUNT_W-1:0];
                REG_TRIP_HOLD:     r_cfg.trip_hold_ticks     <= pwdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (reg_idx)
            REG_DEBOUNCE:      prdata = {16'b0, r_cfg.debounce_ticks};
            REG_RAMP_INTERVAL: prdata = {16'b0, r_cfg.ramp_interval_ticks};
            REG_RAMP_STEP:     prdata = {24'b0, r_cfg.ramp_step};
            REG_RAMP_START:    prdata = {24'b0, r_cfg.ramp_start};
            REG_OC_LEVEL:      prdata = {22'b0, r_cfg.overcurrent_level};
            REG_RECHECK:       prdata = {16'b0, r_cfg.recheck_ticks};
            REG_TRIP_HOLD:     prdata = {16'b0, r_cfg.trip_hold_ticks};
            default:           prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/dmst_core.sv]
// Per-tick control logic and state of the drill motor controller.
`default_nettype none
`include "drill_motor_soft_start_trip_defines.svh"
module dmst_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_advance,
    input  wire dmst_pkg::t_cfg                i_cfg,
    input  wire logic                          i_power_button,
    input  wire logic                          i_direction_button,
    input  wire logic [dmst_pkg::ADC_W-1:0]    i_pot_sample,
    input  wire logic [dmst_pkg::ADC_W-1:0]    i_shunt_sample,
    output dmst_pkg::t_result                  o_result
);
    import dmst_pkg::*;

    // State registers.
    logic               r_powered, r_reversed, r_ramping, r_fault;
    logic [DUTY_W-1:0]  r_ramp_value, r_duty_value;
    logic [COUNT_W-1:0] r_since_pwr, r_since_dir, r_since_ramp;
    t_phase             r_phase;
    logic [COUNT_W-1:0] r_wait_count;
    logic               r_en, r_yel, r_grn;
    logic [DUTY_W-1:0]  r_fwd, r_rev;

    // Next values.
    logic               n_powered, n_reversed, n_ramping, n_fault;
    logic [DUTY_W-1:0]  n_ramp_value, n_duty_value;
    logic [COUNT_W-1:0] n_since_pwr, n_since_dir, n_since_ramp;
    t_phase             n_phase;
    logic [COUNT_W-1:0] n_wait_count;
    logic               n_en, n_yel, n_grn;
    logic [DUTY_W-1:0]  n_fwd, n_rev;

    // Decode signals.
    logic [COUNT_W-1:0] inc_pwr, inc_dir, inc_ramp;
    logic [DUTY_W-1:0]  target;
    logic [DUTY_W:0]    ramp_sum;
    logic               shunt_high, wait_more, cont, skip_power, skip_dir;
    logic               pwr_press, off_path, dir_press, drive, trip, ramp_go;

    // Saturating tick counters, the pot target and the shunt compare.
    assign inc_pwr    = (r_since_pwr == COUNT_MAX) ? r_since_pwr : r_since_pwr + 16'd1;
    assign inc_dir    = (r_since_dir == COUNT_MAX) ? r_since_dir : r_since_dir + 16'd1;
    assign inc_ramp   = (r_since_ramp == COUNT_MAX) ? r_since_ramp : r_since_ramp + 16'd1;
    assign target     = pot_to_target(i_pot_sample);
    assign shunt_high = i_shunt_sample >= i_cfg.overcurrent_level;
    assign wait_more  = r_wait_count > 16'd1;
    assign ramp_sum   = {1'b0, r_ramp_value} + {1'b0, i_cfg.ramp_step};
    assign ramp_go    = (r_ramp_value < target) && (inc_ramp > i_cfg.ramp_interval_ticks);

    // Decide which path this tick takes.
    always_comb begin
        cont       = 1'b0;
        skip_power = 1'b0;
        skip_dir   = 1'b0;
        unique case (r_phase)
            PH_WAIT_PWR: begin
                cont       = !i_power_button;
                skip_power = 1'b1;
            end
            PH_WAIT_DIR: begin
                cont       = !i_direction_button;
                skip_power = 1'b1;
                skip_dir   = 1'b1;
            end
            PH_RECHECK, PH_HOLD: begin
                cont = 1'b0;
            end
            default: begin
                cont = 1'b1;
            end
        endcase
        pwr_press = cont && !skip_power && i_power_button
                    && (inc_pwr > i_cfg.debounce_ticks);
        off_path  = cont && !pwr_press && !r_powered;
        dir_press = cont && !pwr_press && r_powered && !skip_dir && i_direction_button
                    && (inc_dir > i_cfg.debounce_ticks);
        drive     = cont && !pwr_press && r_powered && !dir_press;
        trip      = (r_phase == PH_RECHECK) && !wait_more && shunt_high;
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_WAIT_PWR, PH_WAIT_DIR: begin
                if (cont) begin
                    n_phase = PH_RUN;
                end
            end
            PH_RECHECK: begin
                if (!wait_more) begin
                    n_phase = trip ? PH_HOLD : PH_RUN;
                end
            end
            PH_HOLD: begin
                if (!wait_more) begin
                    n_phase = PH_RUN;
                end
            end
            default: begin
                n_phase = PH_RUN;
            end
        endcase
        priority if (pwr_press) begin
            n_phase = PH_WAIT_PWR;
        end else if (dir_press) begin
            n_phase = PH_WAIT_DIR;
        end else if (drive && shunt_high) begin
            n_phase = PH_RECHECK;
        end else begin
        end
    end

    // Datapath and held outputs.
    always_comb begin
        n_powered    = r_powered;
        n_reversed   = r_reversed;
        n_ramping    = r_ramping;
        n_fault      = r_fault;
        n_ramp_value = r_ramp_value;
        n_duty_value = r_duty_value;
        n_since_pwr  = inc_pwr;
        n_since_dir  = inc_dir;
        n_since_ramp = inc_ramp;
        n_wait_count = r_wait_count;
        n_en         = r_en;
        n_yel        = r_yel;
        n_grn        = r_grn;
        n_fwd        = r_fwd;
        n_rev        = r_rev;

        // A release clears the counter of the button that was held.
        if (r_phase == PH_WAIT_PWR && cont) begin
            n_since_pwr = '0;
        end
        if (r_phase == PH_WAIT_DIR && cont) begin
            n_since_dir = '0;
        end

        // Recheck delay and trip hold count down.
        if ((r_phase == PH_RECHECK || r_phase == PH_HOLD) && wait_more) begin
            n_wait_count = r_wait_count - 16'd1;
        end
        if (trip) begin
            n_fault      = 1'b1;
            n_en         = 1'b0;
            n_wait_count = i_cfg.trip_hold_ticks;
        end
        if (r_phase == PH_HOLD && !wait_more) begin
            n_ramping = 1'b1;
        end

        // Power toggle.
        if (pwr_press) begin
            n_powered = !r_powered;
            if (!r_powered) begin
                n_yel     = !r_yel;
                n_ramping = 1'b1;
            end
        end

        // Powered off: everything dark.
        if (off_path) begin
            n_en    = 1'b0;
            n_fault = 1'b0;
            n_yel   = 1'b0;
            n_grn   = 1'b0;
            n_fwd   = '0;
            n_rev   = '0;
        end

        // Direction toggle.
        if (dir_press) begin
            n_reversed = !r_reversed;
            n_ramping  = 1'b1;
        end

        // Normal drive: soft-start ramp or direct pot tracking.
        if (drive) begin
            n_en = 1'b1;
            if (r_ramping) begin
                if (ramp_go) begin
                    n_ramp_value = ramp_sum[DUTY_W] ? DUTY_MAX : ramp_sum[DUTY_W-1:0];
                    n_duty_value = n_ramp_value;
                    n_since_ramp = '0;
                end else if (r_ramp_value >= target) begin
                    n_ramping    = 1'b0;
                    n_ramp_value = i_cfg.ramp_start;
                end
            end else begin
                n_duty_value = target;
            end
            n_yel = !r_reversed;
            n_grn = r_reversed;
            n_fwd = r_reversed ? '0 : n_duty_value;
            n_rev = r_reversed ? n_duty_value : '0;
            if (shunt_high) begin
                n_wait_count = i_cfg.recheck_ticks;
            end else begin
                n_fault = 1'b0;
            end
        end
    end

    // State update on each accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_powered    <= 1'b0;
            r_reversed   <= 1'b0;
            r_ramping    <= 1'b1;
            r_fault      <= 1'b0;
            r_ramp_value <= RAMP_RESET_VALUE;
            r_duty_value <= '0;
            r_since_pwr  <= COUNT_MAX;
            r_since_dir  <= COUNT_MAX;
            r_since_ramp <= COUNT_MAX;
            r_phase      <= PH_RUN;
            r_wait_count <= '0;
            r_en         <= 1'b0;
            r_yel        <= 1'b0;
            r_grn        <= 1'b0;
            r_fwd        <= '0;
            r_rev        <= '0;
        end else if (i_advance) begin
            r_powered    <= n_powered;
            r_reversed   <= n_reversed;
            r_ramping    <= n_ramping;
            r_fault      <= n_fault;
            r_ramp_value <= n_ramp_value;
            r_duty_value <= n_duty_value;
            r_since_pwr  <= n_since_pwr;
            r_since_dir  <= n_since_dir;
            r_since_ramp <= n_since_ramp;
            r_phase      <= n_phase;
            r_wait_count <= n_wait_count;
            r_en         <= n_en;
            r_yel        <= n_yel;
            r_grn        <= n_grn;
            r_fwd        <= n_fwd;
            r_rev        <= n_rev;
        end
    end

    // The result of a tick is the state it leaves behind.
    always_comb begin
        o_result.drive_enable = n_en;
        o_result.duty_forward = n_fwd;
        o_result.duty_reverse = n_rev;
        o_result.lamp_power   = n_powered;
        o_result.lamp_forward = n_yel;
        o_result.lamp_reverse = n_grn;
        o_result.lamp_fault   = n_fault;
    end

    // Consistency checks on the controller state.
    `DMST_ASSERT_SAME(a_hold_motor_off, r_phase == PH_HOLD, !r_en, "motor enabled during trip hold")
    `DMST_ASSERT_SAME(a_one_leg, r_fwd != 8'd0, r_rev == 8'd0, "both PWM legs driven")
    `DMST_ASSERT_SAME(a_off_dark, !r_powered && r_phase == PH_RUN, !r_en && r_fwd == 8'd0 && r_rev == 8'd0, "outputs live while powered off")
    `DMST_ASSERT_SAME(a_recheck_live, r_phase == PH_RECHECK, r_powered && r_en, "recheck entered while not driving")
    `DMST_ASSERT_NEXT(a_hold_end, i_advance && r_phase == PH_HOLD && r_wait_count <= 16'd1, r_phase == PH_RUN && r_ramping, "trip hold did not end in a soft start")

endmodule
`default_nettype wire

[rtl/core/drill_motor_soft_start_trip.sv]
// Top level of the drill motor controller.
// Flow: a tick transfer lands in the input register; when it advances, the core state and
// the result register load together, and the result is offered until it is taken.
// Throughput: one tick per cycle; while a result waits, one more tick is taken into the
// input register and the input then stalls until the result is taken.
// Reset: synchronous, active low; state and valid flags load their defaults.
`default_nettype none
module drill_motor_soft_start_trip (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    dmst_tick_if.sink                             i_tick,
    dmst_result_if.source                         o_result,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [dmst_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [dmst_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [dmst_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);
    import dmst_pkg::*;

    t_cfg             cfg;
    t_result          core_result;
    logic             advance;
    logic             r_in_valid;
    logic             r_in_pb, r_in_db;
    logic [ADC_W-1:0] r_in_pot, r_in_shunt;
    logic             r_out_valid;
    t_result          r_result;

    // Configuration registers.
    dmst_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The registered tick advances when the result register is free or being emptied.
    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_tick.ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_in_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_in_pb    <= i_tick.power_button;
            r_in_db    <= i_tick.direction_button;
            r_in_pot   <= i_tick.pot_sample;
            r_in_shunt <= i_tick.shunt_sample;
        end
    end

    // Tick processing.
    dmst_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_advance          (advance),
        .i_cfg              (cfg),
        .i_power_button     (r_in_pb),
        .i_direction_button (r_in_db),
        .i_pot_sample       (r_in_pot),
        .i_shunt_sample     (r_in_shunt),
        .o_result           (core_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.drive_enable = r_result.drive_enable;
    assign o_result.duty_forward = r_result.duty_forward;
    assign o_result.duty_reverse = r_result.duty_reverse;
    assign o_result.lamp_power   = r_result.lamp_power;
    assign o_result.lamp_forward = r_result.lamp_forward;
    assign o_result.lamp_reverse = r_result.lamp_reverse;
    assign o_result.lamp_fault   = r_result.lamp_fault;

endmodule
`default_nettype wire

[bench/drill_output_checker.sv]
// Result checker for the drill motor controller: predicts every tick and compares the results.
`timescale 1ns / 1ps
module drill_output_checker
    import dmst_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    dmst_tick_if                       i_tick,
    dmst_result_if                     i_result,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic                  i_pready,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_trips
);

    // Register copy as the block should hold it.
    t_cfg        cfg;

    // Controller state of the prediction.
    logic        pwr_on;
    logic        dir_rev;
    logic        soft_start;
    logic        fault_on;
    logic [7:0]  ramp_lvl;
    logic [7:0]  duty_lvl;
    logic [15:0] pwr_age;
    logic [15:0] dir_age;
    logic [15:0] step_age;
    t_phase      ctl_phase;
    logic [15:0] wait_left;

    // Output latches that repeat while the controller waits.
    logic        hold_en;
    logic        hold_fwd_lamp;
    logic        hold_rev_lamp;
    logic [7:0]  hold_fwd;
    logic [7:0]  hold_rev;

    t_result     expected_results[$];
    int          mismatches = 0;
    int          checked    = 0;
    int          trips      = 0;
    int          pending_r  = 0;
    logic        last_fault = 1'b0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_r;
    assign o_checked    = checked;
    assign o_trips      = trips;

    function automatic void clear_prediction();
        cfg.debounce_ticks      = DEF_DEBOUNCE;
        cfg.ramp_interval_ticks = DEF_RAMP_INTERVAL;
        cfg.ramp_step           = DEF_RAMP_STEP;
        cfg.ramp_start          = DEF_RAMP_START;
        cfg.overcurrent_level   = DEF_OC_LEVEL;
        cfg.recheck_ticks       = DEF_RECHECK;
        cfg.trip_hold_ticks     = DEF_TRIP_HOLD;
        pwr_on        = 1'b0;
        dir_rev       = 1'b0;
        soft_start    = 1'b1;
        fault_on      = 1'b0;
        ramp_lvl      = RAMP_RESET_VALUE;
        duty_lvl      = '0;
        pwr_age       = COUNT_MAX;
        dir_age       = COUNT_MAX;
        step_age      = COUNT_MAX;
        ctl_phase     = PH_RUN;
        wait_left     = '0;
        hold_en       = 1'b0;
        hold_fwd_lamp = 1'b0;
        hold_rev_lamp = 1'b0;
        hold_fwd      = '0;
        hold_rev      = '0;
    endfunction

    function automatic logic [15:0] age_up(input logic [15:0] v);
        return (v == COUNT_MAX) ? v : v + 16'd1;
    endfunction

    function automatic t_result current_outputs();
        t_result r;
        r.drive_enable = hold_en;
        r.duty_forward = hold_fwd;
        r.duty_reverse = hold_rev;
        r.lamp_power   = pwr_on;
        r.lamp_forward = hold_fwd_lamp;
        r.lamp_reverse = hold_rev_lamp;
        r.lamp_fault   = fault_on;
        return r;
    endfunction

    // Advances the controller by one millisecond tick and returns its outputs.
    function automatic t_result drill_tick(input logic pb, input logic db,
                                           input logic [9:0] pot, input logic [9:0] shunt);
        logic       pwr_released;
        logic       dir_released;
        logic [7:0] target;
        logic [8:0] sum;
        int         scaled;
        pwr_released = 1'b0;
        dir_released = 1'b0;
        pwr_age  = age_up(pwr_age);
        dir_age  = age_up(dir_age);
        step_age = age_up(step_age);

        // Waiting phases hold every output until they finish.
        case (ctl_phase)
            PH_WAIT_PWR: begin
                if (pb) return current_outputs();
                pwr_age      = '0;
                ctl_phase    = PH_RUN;
                pwr_released = 1'b1;
            end
            PH_WAIT_DIR: begin
                if (db) return current_outputs();
                dir_age      = '0;
                ctl_phase    = PH_RUN;
                pwr_released = 1'b1;
                dir_released = 1'b1;
            end
            PH_RECHECK: begin
                if (wait_left > 16'd1) begin
                    wait_left = wait_left - 16'd1;
                    return current_outputs();
                end
                if (shunt >= cfg.overcurrent_level) begin
                    fault_on  = 1'b1;
                    hold_en   = 1'b0;
                    ctl_phase = PH_HOLD;
                    wait_left = cfg.trip_hold_ticks;
                end else begin
                    ctl_phase = PH_RUN;
                end
                return current_outputs();
            end
            PH_HOLD: begin
                if (wait_left > 16'd1) begin
                    wait_left = wait_left - 16'd1;
                    return current_outputs();
                end
                soft_start = 1'b1;
                ctl_phase  = PH_RUN;
                return current_outputs();
            end
            default: ctl_phase = PH_RUN;
        endcase

        // Power button toggles power and waits for release.
        if (!pwr_released && pb && pwr_age > cfg.debounce_ticks) begin
            pwr_on = !pwr_on;
            if (pwr_on) begin
                hold_fwd_lamp = !hold_fwd_lamp;
                soft_start    = 1'b1;
            end
            ctl_phase = PH_WAIT_PWR;
            return current_outputs();
        end

        if (!pwr_on) begin
            hold_en       = 1'b0;
            fault_on      = 1'b0;
            hold_fwd_lamp = 1'b0;
            hold_rev_lamp = 1'b0;
            hold_fwd      = '0;
            hold_rev      = '0;
            return current_outputs();
        end

        // Direction button reverses and restarts the soft start.
        if (!dir_released && db && dir_age > cfg.debounce_ticks) begin
            dir_rev    = !dir_rev;
            soft_start = 1'b1;
            ctl_phase  = PH_WAIT_DIR;
            return current_outputs();
        end

        // Soft start ramp toward the pot target, then direct tracking.
        hold_en = 1'b1;
        scaled  = (int'(pot) * 255) / 1023;
        target  = 8'(scaled);
        if (soft_start) begin
            if (ramp_lvl < target && step_age > cfg.ramp_interval_ticks) begin
                sum      = {1'b0, ramp_lvl} + {1'b0, cfg.ramp_step};
                ramp_lvl = sum[8] ? DUTY_MAX : sum[7:0];
                duty_lvl = ramp_lvl;
                step_age = '0;
            end else if (ramp_lvl >= target) begin
                soft_start = 1'b0;
                ramp_lvl   = cfg.ramp_start;
            end
        end else begin
            duty_lvl = target;
        end

        if (!dir_rev) begin
            hold_fwd_lamp = 1'b1;
            hold_rev_lamp = 1'b0;
            hold_fwd      = duty_lvl;
            hold_rev      = '0;
        end else begin
            hold_fwd_lamp = 1'b0;
            hold_rev_lamp = 1'b1;
            hold_fwd      = '0;
            hold_rev      = duty_lvl;
        end

        // A high shunt reading starts the recheck delay.
        if (shunt >= cfg.overcurrent_level) begin
            ctl_phase = PH_RECHECK;
            wait_left = cfg.recheck_ticks;
        end else begin
            fault_on = 1'b0;
        end
        return current_outputs();
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 50) $display("[%0t] result %0d: %s", $time, checked, msg);
    endtask

    task automatic compare_fields(input t_result got, input t_result want);
        if (got.drive_enable !== want.drive_enable)
            report_mismatch($sformatf("drive_enable got %0d expected %0d",
                                      got.drive_enable, want.drive_enable));
        if (got.duty_forward !== want.duty_forward)
            report_mismatch($sformatf("duty_forward got %0d expected %0d",
                                      got.duty_forward, want.duty_forward));
        if (got.duty_reverse !== want.duty_reverse)
            report_mismatch($sformatf("duty_reverse got %0d expected %0d",
                                      got.duty_reverse, want.duty_reverse));
        if (got.lamp_power !== want.lamp_power)
            report_mismatch($sformatf("lamp_power got %0d expected %0d",
                                      got.lamp_power, want.lamp_power));
        if (got.lamp_forward !== want.lamp_forward)
            report_mismatch($sformatf("lamp_forward got %0d expected %0d",
                                      got.lamp_forward, want.lamp_forward));
        if (got.lamp_reverse !== want.lamp_reverse)
            report_mismatch($sformatf("lamp_reverse got %0d expected %0d",
                                      got.lamp_reverse, want.lamp_reverse));
        if (got.lamp_fault !== want.lamp_fault)
            report_mismatch($sformatf("lamp_fault got %0d expected %0d",
                                      got.lamp_fault, want.lamp_fault));
    endtask

    // Watch the register port and both channels at every rising edge.
    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            clear_prediction();
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[APB_ADDR_W-1:2]))
                    REG_DEBOUNCE:      cfg.debounce_ticks      = i_pwdata[15:0];
                    REG_RAMP_INTERVAL: cfg.ramp_interval_ticks = i_pwdata[15:0];
                    REG_RAMP_STEP:     cfg.ramp_step           = i_pwdata[7:0];
                    REG_RAMP_START:    cfg.ramp_start          = i_pwdata[7:0];
                    REG_OC_LEVEL:      cfg.overcurrent_level   = i_pwdata[9:0];
                    REG_RECHECK:       cfg.recheck_ticks       = i_pwdata[15:0];
                    REG_TRIP_HOLD:     cfg.trip_hold_ticks     = i_pwdata[15:0];
                    default: ;
                endcase
            end

            // Each tick transfer yields exactly one expected result.
            if (i_tick.valid && i_tick.ready) begin
                expected_results.push_back(drill_tick(i_tick.power_button,
                                                      i_tick.direction_button,
                                                      i_tick.pot_sample,
                                                      i_tick.shunt_sample));
            end

            if (i_result.valid && i_result.ready) begin
                got.drive_enable = i_result.drive_enable;
                got.duty_forward = i_result.duty_forward;
                got.duty_reverse = i_result.duty_reverse;
                got.lamp_power   = i_result.lamp_power;
                got.lamp_forward = i_result.lamp_forward;
                got.lamp_reverse = i_result.lamp_reverse;
                got.lamp_fault   = i_result.lamp_fault;
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfer with no tick outstanding");
                end else begin
                    want = expected_results.pop_front();
                    compare_fields(got, want);
                end
                if (got.lamp_fault === 1'b1 && !last_fault) trips++;
                last_fault = (got.lamp_fault === 1'b1);
                checked++;
            end
        end
        pending_r <= expected_results.size();
    end

endmodule

[bench/tb_drill_motor_soft_start_trip.sv]
// Testbench top for the drill motor controller: clock, reset, register writes and tick stimulus.
`timescale 1ns / 1ps
module tb_drill_motor_soft_start_trip;
    import dmst_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 24;
    localparam int HOLD_OFF    = 80;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int   fail_count;
    int   pending;
    int   checked;
    int   trips;
    int   ticks_sent      = 0;
    int   cycle_count     = 0;
    int   oc_level        = DEF_OC_LEVEL;
    logic steady          = 1'b0;
    logic hold_off_req    = 1'b0;
    logic hold_off_taken  = 1'b0;
    int   hold_left       = 0;
    logic seen_power      = 1'b0;

    dmst_tick_if   tick_ch();
    dmst_result_if result_ch();

    drill_motor_soft_start_trip uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    drill_output_checker out_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_ch),
        .i_result     (result_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_trips      (trips)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("simulation failed");
            $finish;
        end
    end

    // Result receiver: random stalls, one long hold-off on request, and steady stretches.
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (hold_off_req && !hold_off_taken) begin
                result_ch.ready <= 1'b0;
                hold_off_taken = 1'b1;
                hold_left      = HOLD_OFF - 1;
            end else begin
                result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Track the power lamp so that random presses keep the motor mostly running.
    always @(posedge i_clk) begin
        if (result_ch.valid && result_ch.ready) seen_power <= result_ch.lamp_power;
    end

    task automatic write_reg(input t_reg_idx idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_settings(input int deb, input int interval, input int step,
                                 input int start, input int level, input int recheck,
                                 input int hold);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_RAMP_INTERVAL, interval);
        write_reg(REG_RAMP_STEP, step);
        write_reg(REG_RAMP_START, start);
        write_reg(REG_OC_LEVEL, level);
        write_reg(REG_RECHECK, recheck);
        write_reg(REG_TRIP_HOLD, hold);
        oc_level = level;
    endtask

    // Stop offering ticks, then wait until every expected result has arrived.
    task automatic drain();
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One tick transfer, with an occasional idle gap in front of it.
    task automatic send_tick(input logic pb, input logic db,
                             input logic [9:0] pot, input logic [9:0] shunt);
        int gap;
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            gap = $urandom_range(3, 1);
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_ch.valid            <= 1'b1;
        tick_ch.power_button     <= pb;
        tick_ch.direction_button <= db;
        tick_ch.pot_sample       <= pot;
        tick_ch.shunt_sample     <= shunt;
        do @(posedge i_clk); while (!tick_ch.ready);
        ticks_sent++;
    endtask

    task automatic send_repeat(input int count, input logic pb, input logic db,
                               input logic [9:0] pot, input logic [9:0] shunt);
        for (int k = 0; k < count; k++) send_tick(pb, db, pot, shunt);
    endtask

    // Random ticks built from press-hold-release sequences, with some noise mixed in.
    task automatic run_random(input int count, input int shunt_top);
        int         held;
        int         pick;
        int         shunt_val;
        logic       pb;
        logic       db;
        logic [9:0] pot;
        held = 0;
        pb   = 1'b0;
        db   = 1'b0;
        pot  = 10'($urandom_range(1023));
        for (int n = 0; n < count; n++) begin
            if (held > 0) begin
                held--;
            end else if (pb || db) begin
                pb = 1'b0;
                db = 1'b0;
            end else begin
                pick = $urandom_range(99);
                if (pick < (seen_power ? 3 : 30)) begin
                    pb   = 1'b1;
                    held = $urandom_range(3);
                end else if (pick < (seen_power ? 9 : 33)) begin
                    db   = 1'b1;
                    held = $urandom_range(3);
                end
            end

            // The pot often drifts, now and then jumps to a random value or an end stop, else holds.
            pick = $urandom_range(99);
            if (pick < 20) pot = 10'($urandom_range(1023));
            else if (pick < 30) pot = ($urandom_range(1)) ? 10'd1023 : 10'd0;
            else if (pick < 60) pot = 10'($urandom_range(pot > 990 ? 1023 : pot + 32,
                                                         pot < 32 ? 0 : pot - 32));

            // Shunt readings sit mostly below the trip level.
            pick = $urandom_range(99);
            if (pick < 5 || oc_level == 0) shunt_val = $urandom_range(1023);
            else if (pick < 85) shunt_val = $urandom_range(oc_level - 1);
            else shunt_val = $urandom_range(1023, oc_level);
            if (shunt_val > shunt_top) shunt_val = shunt_top;

            if ($urandom_range(99) < 8)
                send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), pot, 10'(shunt_val));
            else
                send_tick(pb, db, pot, 10'(shunt_val));
        end
    endtask

    initial begin
        i_rst_n                  <= 1'b0;
        psel                     <= 1'b0;
        penable                  <= 1'b0;
        pwrite                   <= 1'b0;
        paddr                    <= '0;
        pwdata                   <= '0;
        tick_ch.valid            <= 1'b0;
        tick_ch.power_button     <= 1'b0;
        tick_ch.direction_button <= 1'b0;
        tick_ch.pot_sample       <= '0;
        tick_ch.shunt_sample     <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset register values: power on, a debounced second press, direction toggle.
        send_tick(1'b1, 1'b0, 10'd1023, 10'd0);
        send_tick(1'b1, 1'b0, 10'd1023, 10'd0);
        send_repeat(2, 1'b0, 1'b0, 10'd1023, 10'd0);
        send_tick(1'b1, 1'b0, 10'd1023, 10'd0);
        send_tick(1'b0, 1'b0, 10'd1023, 10'd0);
        send_tick(1'b0, 1'b1, 10'd1023, 10'd0);
        send_tick(1'b0, 1'b0, 10'd1023, 10'd0);
        drain();

        // Directed cases with short timers.
        load_settings(2, 1, 40, 0, 600, 3, 5);
        send_repeat(2, 1'b0, 1'b0, 10'd1023, 10'd0);
        send_repeat(2, 1'b0, 1'b0, 10'd0, 10'd0);
        send_repeat(3, 1'b0, 1'b0, 10'd512, 10'd0);
        // Overcurrent still present at the recheck: trip, hold, new soft start.
        send_repeat(4, 1'b0, 1'b0, 10'd1023, 10'd1023);
        send_repeat(4, 1'b0, 1'b0, 10'd1023, 10'd0);
        // Reading exactly at the level on the tick that ends the hold, then just below it.
        send_tick(1'b0, 1'b0, 10'd300, 10'd600);
        send_repeat(3, 1'b0, 1'b0, 10'd300, 10'd599);
        // Direction press, power held through the release, then power off.
        send_repeat(2, 1'b0, 1'b1, 10'd700, 10'd0);
        send_tick(1'b1, 1'b1, 10'd700, 10'd0);
        send_repeat(2, 1'b1, 1'b0, 10'd1023, 10'd0);
        send_tick(1'b0, 1'b0, 10'd1023, 10'd0);
        send_tick(1'b0, 1'b0, 10'd1023, 10'd1023);
        drain();

        // Lowest timer values and a zero trip level.
        load_settings(0, 0, 255, 255, 0, 0, 0);
        run_random(100, 1023);
        drain();

        // Highest debounce and interval: no press is ever taken.
        load_settings(65535, 65535, 0, 0, 1023, 1, 1);
        run_random(60, 1023);
        drain();

        // Zero ramp step, with no idling on either side.
        steady = 1'b1;
        load_settings(4, 3, 0, 20, 900, 6, 8);
        run_random(120, 1023);
        drain();
        steady = 1'b0;

        // Long receiver hold-off while ticks keep coming.
        load_settings(1, 5, 7, 100, 300, 2, 3);
        hold_off_req = 1'b1;
        run_random(150, 1023);
        drain();

        // Longest recheck and hold, with the shunt kept below the level.
        load_settings(3, 2, 128, 200, 1023, 65535, 65535);
        run_random(100, 1022);
        drain();

        load_settings(5, 2, 25, 50, 512, 4, 10);
        run_random(100, 1023);
        tick_ch.valid <= 1'b0;
        drain();

        $display("Sent %0d ticks over eight register settings, including extreme timer values.",
                 ticks_sent);
        $display("Checked %0d results; %0d overcurrent trips were seen.", checked, trips);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
